### rtl/dqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types, constants and helpers for the DNS query encoder.
// ----------------------------------------------------------------------------
package dqe_pkg;

    localparam int BUF_BYTES = 512;   // physical packet buffer size
    localparam int MAX_LABEL = 63;    // longest legal label
    localparam int HDR_BYTES = 12;    // fixed message header length
    localparam int TRL_BYTES = 4;     // type and class after the name

    localparam logic [7:0] DOT_CHAR = 8'd46;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TID    = 3'd0,
        CFG_RD     = 3'd1,
        CFG_QTYPE  = 3'd2,
        CFG_QCLASS = 3'd3,
        CFG_LIMIT  = 3'd4
    } t_cfg_idx;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LBL = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic [15:0] tid;
        logic        rd;
        logic [15:0] qtype;
        logic [15:0] qclass;
        logic [9:0]  limit;    // min(buffer_limit, BUF_BYTES)
    } t_cfg;

    // one classified item, as handed from the front part to the back part
    typedef struct packed {
        logic        hdr;        // emit the header first
        logic        body_err;   // dot closes an empty or oversized label
        logic [9:0]  body_addr;
        logic [7:0]  body_byte;
        logic        last;       // name ends with this item
        logic        end_err;    // final label oversized
        logic        end_dot;    // name ended on a dot
        logic [9:0]  end_ls;     // label start to patch at name end
        logic [5:0]  end_len;
        logic [10:0] tb;         // address of the first type byte
    } t_cmd;

    function automatic logic [7:0] hdr_byte(input t_cfg cfg, input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = cfg.tid[15:8];
            4'd1:    b = cfg.tid[7:0];
            4'd2:    b = {7'd0, cfg.rd};
            4'd5:    b = 8'h01;        // question count low byte
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/dqe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqe_front
// Accepts name characters, tracks label positions and classifies each item.
// ----------------------------------------------------------------------------
module dqe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dqe_pkg::t_cfg    i_cfg,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,    // [7:0] name_char
    input  logic             i_s_tlast,    // end_of_name
    input  logic             i_q_full,
    output logic             o_push,
    output dqe_pkg::t_cmd    o_cmd
);
    import dqe_pkg::*;

    logic        r_in_name;
    logic [9:0]  r_write_pos;
    logic [9:0]  r_label_start;
    logic        r_skipping;

    logic        accept;
    logic        hdr;
    logic        is_dot;
    logic [9:0]  ws;
    logic [9:0]  ls;
    logic [10:0] d;
    logic [10:0] lim;
    logic [10:0] tb;
    logic        body_err;
    logic        end_err;
    logic [9:0]  body_addr;
    logic        ovf;
    logic        err;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;

    always_comb begin
        hdr       = !r_in_name;
        is_dot    = (i_s_tdata == DOT_CHAR);
        ws        = hdr ? 10'(HDR_BYTES + 1) : r_write_pos;
        ls        = hdr ? 10'(HDR_BYTES) : r_label_start;
        d         = {1'b0, ws} - {1'b0, ls};
        lim       = {1'b0, i_cfg.limit};
        body_err  = is_dot && ((d == 11'd1) || (d > 11'(MAX_LABEL + 1)));
        end_err   = !is_dot && (d > 11'(MAX_LABEL));
        body_addr = is_dot ? ls : ws;
        tb        = is_dot ? ({1'b0, ws} + 11'd1) : ({1'b0, ws} + 11'd2);
        ovf       = (hdr && (lim < 11'(HDR_BYTES)))
                 || ({1'b0, body_addr} >= lim)
                 || (i_s_tlast && !end_err && ((tb + 11'(TRL_BYTES - 1)) >= lim));
        err       = ovf || body_err || (i_s_tlast && end_err);

        o_cmd.hdr       = hdr;
        o_cmd.body_err  = body_err;
        o_cmd.body_addr = body_addr;
        o_cmd.body_byte = is_dot ? 8'(d - 11'd1) : i_s_tdata;
        o_cmd.last      = i_s_tlast;
        o_cmd.end_err   = end_err;
        o_cmd.end_dot   = is_dot;
        o_cmd.end_ls    = is_dot ? ws : ls;
        o_cmd.end_len   = d[5:0];
        o_cmd.tb        = tb;
    end

    assign o_push = accept && !r_skipping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_name     <= 1'b0;
            r_write_pos   <= '0;
            r_label_start <= '0;
            r_skipping    <= 1'b0;
        end else if (accept) begin
            if (r_skipping) begin
                if (i_s_tlast) begin
                    r_skipping <= 1'b0;
                end
            end else if (err) begin
                r_in_name  <= 1'b0;
                r_skipping <= !i_s_tlast;
            end else if (i_s_tlast) begin
                r_in_name <= 1'b0;
            end else begin
                r_in_name     <= 1'b1;
                r_write_pos   <= ws + 10'd1;
                r_label_start <= is_dot ? ws : ls;
            end
        end
    end

endmodule

### rtl/dqe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqe_fifo
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module dqe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dqe_pkg::t_cmd    i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output dqe_pkg::t_cmd    o_data
);
    import dqe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### rtl/dqe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqe_back
// Expands queued commands into addressed byte writes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dqe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dqe_pkg::t_cfg    i_cfg,
    input  logic             i_cmd_valid,
    input  dqe_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata,    // [8:0] write_addr, [16:9] write_byte, zero pad
    output logic [1:0]       o_m_tuser,    // [1:0] status
    output logic             o_m_tlast     // packet_done
);
    import dqe_pkg::*;

    typedef enum logic [4:0] {
        PH_HDR   = 5'b00001,
        PH_BODY  = 5'b00010,
        PH_ELEN  = 5'b00100,
        PH_ETERM = 5'b01000,
        PH_TRL   = 5'b10000
    } t_phase;

    t_phase      r_phase;
    logic [3:0]  r_idx;
    logic        r_started;

    logic        r_out_valid;
    logic [8:0]  r_out_addr;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_status;
    logic        r_out_done;

    t_phase      ph;
    t_phase      next_ph;
    logic [3:0]  idx;
    logic [3:0]  next_idx;
    logic [10:0] addr;
    logic [7:0]  wbyte;
    logic        lerr;
    logic        ovf;
    logic        cmd_end;
    logic        pkt_done;
    logic        fire;

    always_comb begin
        ph       = r_started ? r_phase : (i_cmd.hdr ? PH_HDR : PH_BODY);
        idx      = r_started ? r_idx : 4'd0;
        next_ph  = ph;
        next_idx = 4'd0;
        addr     = '0;
        wbyte    = '0;
        lerr     = 1'b0;
        cmd_end  = 1'b0;
        pkt_done = 1'b0;
        unique case (ph)
            PH_HDR: begin
                addr  = {7'd0, idx};
                wbyte = hdr_byte(i_cfg, idx);
                if (idx == 4'(HDR_BYTES - 1)) begin
                    next_ph = PH_BODY;
                end else begin
                    next_idx = idx + 4'd1;
                end
            end
            PH_BODY: begin
                lerr    = i_cmd.body_err;
                addr    = {1'b0, i_cmd.body_addr};
                wbyte   = i_cmd.body_byte;
                cmd_end = !i_cmd.last;
                next_ph = PH_ELEN;
            end
            PH_ELEN: begin
                lerr    = i_cmd.end_err;
                addr    = {1'b0, i_cmd.end_ls};
                wbyte   = i_cmd.end_dot ? 8'd0 : {2'd0, i_cmd.end_len};
                next_ph = i_cmd.end_dot ? PH_TRL : PH_ETERM;
            end
            PH_ETERM: begin
                addr    = i_cmd.tb - 11'd1;
                next_ph = PH_TRL;
            end
            PH_TRL: begin
                addr = i_cmd.tb + {7'd0, idx};
                case (idx[1:0])
                    2'd0:    wbyte = i_cfg.qtype[15:8];
                    2'd1:    wbyte = i_cfg.qtype[7:0];
                    2'd2:    wbyte = i_cfg.qclass[15:8];
                    default: wbyte = i_cfg.qclass[7:0];
                endcase
                pkt_done = (idx == 4'(TRL_BYTES - 1));
                cmd_end  = pkt_done;
                next_idx = idx + 4'd1;
            end
            default: begin
                cmd_end = 1'b1;
            end
        endcase
        ovf  = (addr >= {1'b0, i_cfg.limit});
        fire = i_cmd_valid && (!r_out_valid || i_m_tready);
    end

    // an error result ends the command as well
    assign o_cmd_pop = fire && (lerr || ovf || cmd_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_phase     <= PH_HDR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (o_cmd_pop) begin
                r_started <= 1'b0;
            end else if (fire) begin
                r_started <= 1'b1;
                r_phase   <= next_ph;
                r_idx     <= next_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (lerr || ovf) begin
                r_out_addr   <= '0;
                r_out_byte   <= '0;
                r_out_status <= lerr ? ST_LBL : ST_OVF;
                r_out_done   <= 1'b1;
            end else begin
                r_out_addr   <= addr[8:0];
                r_out_byte   <= wbyte;
                r_out_status <= ST_OK;
                r_out_done   <= pkt_done;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_byte, r_out_addr};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_done;

endmodule

### rtl/dns_query_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_encoder_top
// Builds a DNS query message as addressed byte writes from host name chars.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+-------------------------------
//  s        | in        | i_s_tvalid/o_s_tready  | tdata name_char, tlast end_of_name
//  m        | out       | o_m_tvalid/i_m_tready  | tdata addr+byte, tuser status,
//           |           |                        | tlast packet_done
//  cfg      | in        | i_cfg_valid/o_cfg_ready| index, 16-bit write data
//
//  The front part takes one character per cycle while the command queue has
//  room. The back part emits one byte write per cycle while the output is not
//  stalled: a first character of a name costs 13 results, a middle character
//  1, a name end up to 7, and a name of a single character 19. Output
//  throughput is set by the single write path of the back part.
//  Reset is synchronous, active low; it restores register defaults and empties
//  the queue. A stalled output holds its item; the queue absorbs bursts.
//
module dns_query_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] name_char
    input  logic        i_s_tlast,     // end_of_name
    // byte write output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,     // [8:0] write_addr, [16:9] write_byte, zero pad
    output logic [1:0]  o_m_tuser,     // [1:0] status
    output logic        o_m_tlast,     // packet_done
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import dqe_pkg::*;

    logic [15:0] r_tid;
    logic        r_rd;
    logic [15:0] r_qtype;
    logic [15:0] r_qclass;
    logic [9:0]  r_buf_limit;

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    // Always take config writes; the user must write them only while the block is idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tid       <= 16'h1234;
            r_rd        <= 1'b1;
            r_qtype     <= 16'h0001;
            r_qclass    <= 16'h0001;
            r_buf_limit <= 10'(BUF_BYTES);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TID:    r_tid       <= i_cfg_data;
                CFG_RD:     r_rd        <= i_cfg_data[0];
                CFG_QTYPE:  r_qtype     <= i_cfg_data;
                CFG_QCLASS: r_qclass    <= i_cfg_data;
                CFG_LIMIT:  r_buf_limit <= i_cfg_data[9:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // Clamp the programmed limit to the physical buffer size.
    always_comb begin
        cfg.tid    = r_tid;
        cfg.rd     = r_rd;
        cfg.qtype  = r_qtype;
        cfg.qclass = r_qclass;
        cfg.limit  = ({3'd0, r_buf_limit} > 13'(BUF_BYTES)) ? 10'(BUF_BYTES) : r_buf_limit;
    end

    // Front: classify characters and advance label bookkeeping.
    dqe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Queue: decouple classification from write generation.
    dqe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_cmd)
    );

    // Back: expand each command into header, body, label length, terminator and trailer writes.
    dqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

### verif/dqe_query_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqe_query_checker
// Watches the character, byte-write and register channels of the DNS query
// encoder, builds the byte writes each accepted character must cause and
// compares every accepted write with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module dqe_query_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import dqe_pkg::*;

    typedef struct packed {
        logic [8:0] addr;
        logic [7:0] data;
        logic [1:0] status;
        logic       done;
    } t_byte_write;

    t_byte_write pending_writes[$];
    int          mismatches = 0;

    // register copy
    logic [15:0] cfg_tid;
    logic        cfg_rd;
    logic [15:0] cfg_qtype;
    logic [15:0] cfg_qclass;
    logic [9:0]  cfg_limit;

    // encoder state
    logic        in_query;
    int unsigned next_addr;
    int unsigned len_addr;
    logic        ended_on_dot;
    logic        dropping_name;

    // per-character scratch
    logic        char_failed;
    int unsigned char_limit;

    task automatic report_mismatch(input string msg);
        $display("[%0t] dqe mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_error(input logic [1:0] status);
        t_byte_write w;
        if (char_failed) return;
        w.addr   = '0;
        w.data   = '0;
        w.status = status;
        w.done   = 1'b1;
        pending_writes.push_back(w);
        char_failed = 1'b1;
    endtask

    task automatic push_write(input int unsigned addr, input logic [7:0] b, input logic done);
        t_byte_write w;
        if (char_failed) return;
        if (addr >= char_limit) begin
            push_error(ST_OVF);
            return;
        end
        w.addr   = addr[8:0];
        w.data   = b;
        w.status = ST_OK;
        w.done   = done;
        pending_writes.push_back(w);
    endtask

    task automatic encode_char(input logic [7:0] ch, input logic last);
        int unsigned len;
        int          i;
        char_failed = 1'b0;
        char_limit  = (cfg_limit < BUF_BYTES) ? cfg_limit : BUF_BYTES;

        // drop the tail of a failed name
        if (dropping_name) begin
            if (last) dropping_name = 1'b0;
            return;
        end

        if (!in_query) begin
            push_write(0, cfg_tid[15:8], 1'b0);
            push_write(1, cfg_tid[7:0], 1'b0);
            push_write(2, {7'd0, cfg_rd}, 1'b0);
            push_write(3, 8'h00, 1'b0);
            push_write(4, 8'h00, 1'b0);
            push_write(5, 8'h01, 1'b0);
            for (i = 6; i < HDR_BYTES; i++)
                push_write(i, 8'h00, 1'b0);
            len_addr     = HDR_BYTES;
            next_addr    = HDR_BYTES + 1;
            in_query     = 1'b1;
            ended_on_dot = 1'b0;
        end

        if (!char_failed) begin
            if (ch != DOT_CHAR) begin
                push_write(next_addr, ch, 1'b0);
                next_addr++;
                ended_on_dot = 1'b0;
            end else begin
                len = next_addr - len_addr - 1;
                if (len == 0 || len > MAX_LABEL) begin
                    push_error(ST_LBL);
                end else begin
                    push_write(len_addr, len[7:0], 1'b0);
                    len_addr = next_addr;
                    next_addr++;
                    ended_on_dot = 1'b1;
                end
            end
        end

        if (!char_failed && last) begin
            if (ended_on_dot) begin
                // the reserved length byte becomes the terminator
                push_write(len_addr, 8'h00, 1'b0);
            end else begin
                len = next_addr - len_addr - 1;
                if (len > MAX_LABEL) begin
                    push_error(ST_LBL);
                end else begin
                    push_write(len_addr, len[7:0], 1'b0);
                    push_write(next_addr, 8'h00, 1'b0);
                    next_addr++;
                end
            end
            push_write(next_addr, cfg_qtype[15:8], 1'b0);
            push_write(next_addr + 1, cfg_qtype[7:0], 1'b0);
            push_write(next_addr + 2, cfg_qclass[15:8], 1'b0);
            push_write(next_addr + 3, cfg_qclass[7:0], 1'b1);
            next_addr += TRL_BYTES;
            in_query     = 1'b0;
            ended_on_dot = 1'b0;
        end

        if (char_failed) begin
            in_query      = 1'b0;
            ended_on_dot  = 1'b0;
            dropping_name = !last;
        end
        next_addr = next_addr & 32'h3ff;
        len_addr  = len_addr & 32'h3ff;
    endtask

    task automatic check_write();
        t_byte_write got;
        t_byte_write want;
        got.addr   = i_m_tdata[8:0];
        got.data   = i_m_tdata[16:9];
        got.status = i_m_tuser;
        got.done   = i_m_tlast;
        if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write addr %0d byte %02h status %0d done %0d",
                                      got.addr, got.data, got.status, got.done));
            return;
        end
        want = pending_writes.pop_front();
        if (got.addr !== want.addr || got.data !== want.data ||
            got.status !== want.status || got.done !== want.done)
            report_mismatch($sformatf(
                "got addr %0d byte %02h status %0d done %0d, want %0d %02h %0d %0d",
                got.addr, got.data, got.status, got.done,
                want.addr, want.data, want.status, want.done));
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [15:0] value);
        case (idx)
            CFG_TID:    cfg_tid    = value;
            CFG_RD:     cfg_rd     = value[0];
            CFG_QTYPE:  cfg_qtype  = value;
            CFG_QCLASS: cfg_qclass = value;
            CFG_LIMIT:  cfg_limit  = value[9:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_tid       = 16'h1234;
            cfg_rd        = 1'b1;
            cfg_qtype     = 16'h0001;
            cfg_qclass    = 16'h0001;
            cfg_limit     = 10'd512;
            in_query      = 1'b0;
            next_addr     = 0;
            len_addr      = 0;
            ended_on_dot  = 1'b0;
            dropping_name = 1'b0;
            pending_writes.delete();
        end else begin
            // retire before predicting: a write never answers a character of the same edge
            if (i_m_tvalid && i_m_tready) check_write();
            if (i_cfg_valid && i_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready) encode_char(i_s_tdata, i_s_tlast);
        end
        o_pending    <= pending_writes.size();
        o_fail_count <= mismatches;
    end

endmodule

### verif/tb_dns_query_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_query_encoder_top
// Drives host names into the DNS query encoder one character per item under
// several register settings, with random idling on both streams, and lets a
// checker beside the block predict and compare every byte write.
// ----------------------------------------------------------------------------
module tb_dns_query_encoder_top;
    import dqe_pkg::*;

    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int          SETTLE_CYCLES = 32;    // covers dropped characters still in flight
    localparam logic [2:0]  CFG_UNUSED    = 3'd7;  // index with no register behind it

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_TID;
    logic [15:0] cfg_data  = 16'h0000;

    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_ready;

    int          fail_count;
    int          pending;
    int          cycles = 0;

    // stimulus knobs shared with the receiver process
    bit          idle_on   = 1'b1;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;

    logic [7:0]  host_name[$];

    dns_query_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    dqe_query_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_dns_query_encoder_top: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls while idling is on, one long hold-off on request.
    initial begin : rx_side
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until accepted. Valid stays high afterwards so
    // back-to-back items never see a low-then-high in the same step.
    task automatic send_item(input logic [7:0] ch, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop valid, then hold until every predicted write has been taken.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // Registers change only with the block idle.
    task automatic configure(input logic [15:0] tid, input logic [15:0] rd,
                             input logic [15:0] qtype, input logic [15:0] qclass,
                             input logic [15:0] limit, input bit poke_unused);
        wait_idle();
        if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        write_reg(CFG_TID, tid);
        write_reg(CFG_RD, rd);
        write_reg(CFG_QTYPE, qtype);
        write_reg(CFG_QCLASS, qclass);
        write_reg(CFG_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == DOT_CHAR);
        return c;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) host_name.push_back(s[i]);
    endfunction

    function automatic void add_label(input int n);
        for (int i = 0; i < n; i++) host_name.push_back(label_char());
    endfunction

    // Send the whole name, marking the final character, and clear it.
    task automatic send_host_name();
        for (int i = 0; i < host_name.size(); i++)
            send_item(host_name[i], i == host_name.size() - 1);
        host_name.delete();
    endtask

    // Mostly well-formed names with random content; some broken, some noise.
    function automatic void build_random_name();
        int kind;
        int labels;
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            labels = $urandom_range(1, 4);
            for (int k = 0; k < labels; k++) begin
                if (k != 0) host_name.push_back(DOT_CHAR);
                add_label((kind == 6) ? $urandom_range(15, 40) : $urandom_range(1, 8));
            end
            if ($urandom_range(0, 4) == 0) host_name.push_back(DOT_CHAR);
            // break it: a stray dot makes an empty label or splits one
            if (kind == 7)
                host_name.insert($urandom_range(0, host_name.size()), DOT_CHAR);
        end else begin
            labels = $urandom_range(1, 6);
            for (int k = 0; k < labels; k++)
                host_name.push_back(($urandom_range(0, 2) == 0) ? DOT_CHAR
                                                                : 8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic logic [15:0] random_limit();
        return ($urandom_range(0, 2) == 0) ? 16'($urandom_range(18, 40))
                                           : 16'($urandom_range(41, 512));
    endfunction

    initial begin : stimulus
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset register values ---
        add_text("a");                       // one character: header, body and trailer
        send_host_name();
        host_name.push_back(8'h00);          // character zero is an ordinary character
        host_name.push_back(8'hff);
        host_name.push_back(8'h01);
        send_host_name();
        add_text("ab.");                     // trailing dot becomes the terminator
        send_host_name();
        add_text(".xy");                     // dot at name start, tail dropped
        send_host_name();
        add_text("a..b");                    // two dots in a row
        send_host_name();
        add_text(".");                       // lone dot that also ends the name
        send_host_name();
        add_text("q.rs");
        send_host_name();

        // --- smallest buffer, other extremes; rd written with upper bits set ---
        configure(16'hffff, 16'h0002, 16'hffff, 16'h0000, 16'd18, 1'b1);
        add_text("a");                       // class low byte lands on the limit
        send_host_name();
        add_text("abcdefg");                 // overflow mid-name, rest dropped
        send_host_name();
        configure(16'h8001, 16'h0001, 16'h001c, 16'h0001, 16'd19, 1'b0);
        add_text("a");                       // last write exactly below the limit
        send_host_name();
        add_text("ab");
        send_host_name();

        // --- full buffer, label length extreme ---
        configure(16'h0000, 16'h0001, 16'h00ff, 16'hff00, 16'd512, 1'b0);
        add_label(MAX_LABEL + 1);            // final label too long
        send_host_name();

        // --- random names under random settings ---
        for (int phase = 0; phase < 3; phase++) begin
            configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      random_limit(), 1'b0);
            // stall the receiver while the sender keeps offering items
            if (phase == 1) hold_req = 1'b1;
            sent = 0;
            while (sent < 6) begin
                build_random_name();
                sent += host_name.size();
                send_host_name();
                // pause the sender until everything predicted has come out
                if (phase == 2) wait_idle();
            end
        end

        // --- closing stretch, no idling on either side ---
        idle_on = 1'b0;
        configure(16'($urandom_range(0, 65535)), 16'h0001, 16'h0001, 16'h0001,
                  16'd512, 1'b0);
        sent = 0;
        while (sent < 6) begin
            build_random_name();
            sent += host_name.size();
            send_host_name();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_dns_query_encoder_top: done, clean");
        end else begin
            $display("tb_dns_query_encoder_top: done, errors");
        end
        $finish;
    end

endmodule
